>>> rtl/dfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfp_pkg;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int NUM_W  = 32;
  localparam int DEN_W  = 31;
  localparam int ST_W   = 3;
  // Digit accumulator: wide enough for eleven decimal digits
  localparam int ACC_W  = 37;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_NUM_RANGE   = 3'd1;
  localparam logic [ST_W-1:0] ST_NUM_INVALID = 3'd2;
  localparam logic [ST_W-1:0] ST_DEN_RANGE   = 3'd3;
  localparam logic [ST_W-1:0] ST_DEN_INVALID = 3'd4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  // Magnitude limits for int32
  localparam logic [ACC_W-1:0] LIM_POS = 37'd2147483647;
  localparam logic [ACC_W-1:0] LIM_NEG = 37'd2147483648;

  // Parser phases
  typedef enum logic [5:0] {
    PH_SKIP      = 6'b000001,
    PH_NUM_FIRST = 6'b000010,
    PH_NUM_DIGS  = 6'b000100,
    PH_DEN_FIRST = 6'b001000,
    PH_DEN_DIGS  = 6'b010000,
    PH_DISCARD   = 6'b100000
  } phase_t;

  // One parse result from the core to the output register
  typedef struct packed {
    logic                    valid;
    logic signed [NUM_W-1:0] numerator;
    logic [DEN_W-1:0]        denominator;
    logic [ST_W-1:0]         status;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/dfp_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module dfp_parse
  import dfp_pkg::*;
#(
  parameter int MAX_DIGITS = 11
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic [CHAR_W-1:0] char_c,
  output res_t                   res
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  phase_t                  phase_r, phase_nxt;
  logic                    neg_r, neg_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [NUM_W-1:0] hold_r, hold_nxt;

  logic                    is_ws, is_dig, is_minus, is_slash;
  logic [ACC_W-1:0]        dig;
  logic [ACC_W-1:0]        acc_step;
  logic                    cnt_full;
  logic                    num_over, den_over;
  logic [NUM_W-1:0]        num_val;
  phase_t                  err_phase;

  // Character classes
  assign is_ws    = (char_c == CH_SPACE) || (char_c >= CH_TAB && char_c <= CH_CR);
  assign is_dig   = (char_c >= CH_ZERO) && (char_c <= CH_NINE);
  assign is_minus = (char_c == CH_MINUS);
  assign is_slash = (char_c == CH_SLASH);
  assign dig      = ACC_W'(char_c[3:0]);

  // accum * 10 + digit, wraps at accumulator width
  assign acc_step = {acc_r[ACC_W-4:0], 3'b000} + {acc_r[ACC_W-2:0], 1'b0} + dig;
  assign cnt_full = (cnt_r >= CNT_W'(MAX_DIGITS));

  // Range checks and signed numerator value
  assign num_over  = neg_r ? (acc_r > LIM_NEG) : (acc_r > LIM_POS);
  assign den_over  = (acc_r > LIM_POS);
  assign num_val   = neg_r ? (NUM_W'(0) - acc_r[NUM_W-1:0]) : acc_r[NUM_W-1:0];
  // after an error the terminating whitespace resumes scanning
  assign err_phase = is_ws ? PH_SKIP : PH_DISCARD;

  // Next state and result
  always_comb begin
    phase_nxt       = phase_r;
    neg_nxt         = neg_r;
    acc_nxt         = acc_r;
    cnt_nxt         = cnt_r;
    hold_nxt        = hold_r;
    res.valid       = 1'b0;
    res.numerator   = '0;
    res.denominator = '0;
    res.status      = ST_OK;
    unique case (phase_r)
      PH_NUM_FIRST: begin
        if (is_dig) begin
          acc_nxt   = dig;
          cnt_nxt   = CNT_W'(1);
          phase_nxt = PH_NUM_DIGS;
        end else begin
          res.valid  = 1'b1;
          res.status = ST_NUM_INVALID;
          phase_nxt  = err_phase;
        end
      end
      PH_NUM_DIGS: begin
        if (is_dig) begin
          if (cnt_full) begin
            res.valid  = 1'b1;
            res.status = ST_NUM_RANGE;
            phase_nxt  = PH_DISCARD;
          end else begin
            acc_nxt = acc_step;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else if (num_over) begin
          res.valid  = 1'b1;
          res.status = ST_NUM_RANGE;
          phase_nxt  = err_phase;
        end else if (is_slash) begin
          hold_nxt  = num_val;
          phase_nxt = PH_DEN_FIRST;
        end else begin
          res.valid       = 1'b1;
          res.numerator   = num_val;
          res.denominator = DEN_W'(1);
          phase_nxt       = PH_SKIP;
        end
      end
      PH_DEN_FIRST: begin
        res.numerator = hold_r;
        if (is_dig) begin
          acc_nxt   = dig;
          cnt_nxt   = CNT_W'(1);
          phase_nxt = PH_DEN_DIGS;
        end else begin
          res.valid  = 1'b1;
          res.status = ST_DEN_INVALID;
          phase_nxt  = err_phase;
        end
      end
      PH_DEN_DIGS: begin
        res.numerator = hold_r;
        if (is_dig) begin
          if (cnt_full) begin
            res.valid  = 1'b1;
            res.status = ST_DEN_RANGE;
            phase_nxt  = PH_DISCARD;
          end else begin
            acc_nxt = acc_step;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else if (den_over) begin
          res.valid  = 1'b1;
          res.status = ST_DEN_RANGE;
          phase_nxt  = err_phase;
        end else begin
          res.valid       = 1'b1;
          res.denominator = acc_r[DEN_W-1:0];
          phase_nxt       = PH_SKIP;
        end
      end
      PH_DISCARD: begin
        phase_nxt = is_ws ? PH_SKIP : PH_DISCARD;
      end
      default: begin
        // skip whitespace; a non-blank opens an entry and is handled as its first char
        if (!is_ws) begin
          neg_nxt = 1'b0;
          acc_nxt = '0;
          cnt_nxt = '0;
          if (is_minus) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_NUM_FIRST;
          end else if (is_dig) begin
            acc_nxt   = dig;
            cnt_nxt   = CNT_W'(1);
            phase_nxt = PH_NUM_DIGS;
          end else begin
            res.valid  = 1'b1;
            res.status = ST_NUM_INVALID;
            phase_nxt  = err_phase;
          end
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
    endcase
  end

  // State registers advance once per processed character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      cnt_r   <= '0;
      hold_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/decimal_fraction_parser_top.sv
// A character accepted into the input register is parsed there and its result moves
//   to the out_ port through the result register once that register is free.
// Throughput: one character per cycle unless out_stall holds a result; the parse step
//   is one multiply-by-ten-and-add plus a phase update between input and result registers.
// Reset: synchronous, active low; the parser returns to whitespace skipping
//   and both pipeline registers are emptied.
`timescale 1ns / 1ps
`default_nettype none

module decimal_fraction_parser_top
  import dfp_pkg::*;
#(
  parameter int MAX_DIGITS = 11
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [CHAR_W-1:0]       in_char_in,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [NUM_W-1:0]      out_numerator,
  output logic [DEN_W-1:0]             out_denominator,
  output logic [ST_W-1:0]              out_status
);

  logic                    in_valid_r;
  logic [CHAR_W-1:0]       char_r;
  logic                    out_valid_r;
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den_r;
  logic [ST_W-1:0]         st_r;
  logic                    out_free;
  logic                    fire;
  res_t                    res;

  // Handshake: the held character is processed when the result register can take it
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_char_in;
    end
  end

  // Parser state and next-state logic
  dfp_parse #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .char_c(char_r),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      num_r <= res.numerator;
      den_r <= res.denominator;
      st_r  <= res.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_numerator   = num_r;
  assign out_denominator = den_r;
  assign out_status      = st_r;

  // Input side only stalls behind a held result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a held result");

  // Any error result reports a zero denominator
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && st_r != ST_OK) |-> (den_r == '0))
    else $error("error result with nonzero denominator");

  // Numerator errors also clear the numerator
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (st_r == ST_NUM_RANGE || st_r == ST_NUM_INVALID)) |-> (num_r == '0))
    else $error("numerator error with nonzero numerator");

  // Status code stays within the defined set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (st_r <= ST_DEN_INVALID))
    else $error("undefined status code");

endmodule

`default_nettype wire
